/* sv/raycast_column_pixel_shader_assert.svh */
`ifndef RAYCAST_COLUMN_PIXEL_SHADER_ASSERT_SVH
`define RAYCAST_COLUMN_PIXEL_SHADER_ASSERT_SVH

// These expect signals named clock and reset in the scope of use.

// expr must never be true outside reset
`define RCCPS_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

// cons holds in the same cycle as ante
`define RCCPS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons holds in the cycle after ante
`define RCCPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/rccps_pkg.sv */
`timescale 1ns / 1ps

package rccps_pkg;

   localparam int SCREEN_HEIGHT = 512;
   localparam int TEX_SIZE      = 64;
   localparam int TEX_COUNT     = 4;

   localparam int TEX_AREA    = TEX_SIZE * TEX_SIZE;
   localparam int STORE_DEPTH = TEX_COUNT * TEX_AREA;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int TEX_RW      = $clog2(TEX_SIZE);

   localparam int COLOR_W   = 32;
   localparam int ADDR_W    = 22;
   localparam int PITCH_W   = 13;
   localparam int ROW_W     = 9;
   localparam int COL_W     = 10;
   localparam int LH_W      = 16;
   localparam int TCOL_W    = 6;
   localparam int SEL_W     = 2;
   localparam int LIDX_W    = 12;
   localparam int CSR_IDX_W = 2;

   // signed row offset y - H/2 + lh/2, and its magnitude
   localparam int N_W     = LH_W + 2;
   localparam int NMAG_W  = LH_W + 1;
   localparam int NUMER_W = NMAG_W + TEX_RW;
   localparam logic signed [N_W-1:0] HALF_H = N_W'(SCREEN_HEIGHT / 2);

   // texel row divider: quotient bits spread over a fixed number of stages
   localparam int DIV_STAGES = 3;
   localparam int DIV_BPS    = (TEX_RW + DIV_STAGES - 1) / DIV_STAGES;

   localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(1024);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CEILING_COLOR = 2'd0,
      CSR_FLOOR_COLOR   = 2'd1,
      CSR_ROW_PITCH     = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_SHADE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REGION_CEILING = 2'd0,
      REGION_WALL    = 2'd1,
      REGION_FLOOR   = 2'd2
   } region_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [COL_W-1:0]     pixel_col;
      logic [ROW_W-1:0]     pixel_row;
      logic [ROW_W-1:0]     span_start;
      logic [ROW_W-1:0]     span_end;
      logic [LH_W-1:0]      wall_height;
      logic [TCOL_W-1:0]    tex_col;
      logic [SEL_W-1:0]     tex_select;
      logic [LIDX_W-1:0]    load_index;
      logic [COLOR_W-1:0]   load_color;
   } item_type;

   typedef struct packed {
      cmd_type              cmd;
      region_type           region;
      logic [SEL_W-1:0]     tex_select;
      logic [TEX_RW-1:0]    tex_col;
      logic [LIDX_W-1:0]    load_index;
      logic [COLOR_W-1:0]   load_color;
      logic [COL_W-1:0]     pixel_col;
      logic [ADDR_W-1:0]    addr_prod;
      logic                 row_zero;
      logic                 row_sat;
   } pipe_type;

   typedef struct packed {
      logic [LH_W-1:0]   rem;
      logic [TEX_RW-1:0] quot;
      logic [TEX_RW-1:0] low;
      logic [LH_W-1:0]   lh;
   } div_type;

   function automatic logic tex_in_range(logic [SEL_W-1:0] sel);
      return int'(sel) < TEX_COUNT;
   endfunction

   function automatic logic load_in_range(logic [SEL_W-1:0] sel, logic [LIDX_W-1:0] idx);
      return (int'(sel) < TEX_COUNT) && (int'(idx) < TEX_AREA);
   endfunction

   function automatic logic [TEX_RW-1:0] clamp_col(logic [TCOL_W-1:0] col);
      if (int'(col) >= TEX_SIZE) begin
         return TEX_RW'(TEX_SIZE - 1);
      end
      return TEX_RW'(col);
   endfunction

   function automatic logic [STORE_AW-1:0] texel_addr(logic [SEL_W-1:0] sel,
                                                      logic [TEX_RW-1:0] row,
                                                      logic [TEX_RW-1:0] col);
      return STORE_AW'(sel) * STORE_AW'(TEX_AREA) + STORE_AW'(row) * STORE_AW'(TEX_SIZE)
             + STORE_AW'(col);
   endfunction

   function automatic logic [STORE_AW-1:0] load_addr(logic [SEL_W-1:0] sel,
                                                     logic [LIDX_W-1:0] idx);
      return STORE_AW'(sel) * STORE_AW'(TEX_AREA) + STORE_AW'(idx);
   endfunction

endpackage

/* sv/rccps_if.sv */
`timescale 1ns / 1ps

interface rccps_req_if import rccps_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [COL_W-1:0]     pixel_col;
   logic [ROW_W-1:0]     pixel_row;
   logic [ROW_W-1:0]     span_start;
   logic [ROW_W-1:0]     span_end;
   logic [LH_W-1:0]      wall_height;
   logic [TCOL_W-1:0]    tex_col;
   logic [SEL_W-1:0]     tex_select;
   logic [LIDX_W-1:0]    load_index;
   logic [COLOR_W-1:0]   load_color;

   modport source (
      output valid, cmd, pixel_col, pixel_row, span_start, span_end, wall_height,
             tex_col, tex_select, load_index, load_color,
      input  ready
   );

   modport sink (
      input  valid, cmd, pixel_col, pixel_row, span_start, span_end, wall_height,
             tex_col, tex_select, load_index, load_color,
      output ready
   );
endinterface

interface rccps_rsp_if import rccps_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ADDR_W-1:0]    frame_address;
   logic [COLOR_W-1:0]   pixel_color;
   logic [1:0]           region;

   modport source (
      output valid, frame_address, pixel_color, region,
      input  ready
   );

   modport sink (
      input  valid, frame_address, pixel_color, region,
      output ready
   );
endinterface

/* sv/rccps_ram.sv */
`timescale 1ns / 1ps

module rccps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/rccps_front.sv */
`timescale 1ns / 1ps
`include "raycast_column_pixel_shader_assert.svh"

module rccps_front import rccps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  item_type           in_item,
   input  logic [PITCH_W-1:0] row_pitch,
   output logic               out_valid,
   output pipe_type           out_pipe,
   output div_type            out_div
);

   logic                     s1_valid_ff;
   item_type                 s1_item_ff;
   logic                     s2_valid_ff;
   pipe_type                 s2_pipe_ff;
   pipe_type                 s2_pipe_in;
   div_type                  s2_div_ff;
   div_type                  s2_div_in;

   logic [LH_W-1:0]          lh_eff;
   logic signed [N_W-1:0]    row_off;
   logic [NMAG_W-1:0]        row_mag;
   logic [NUMER_W-1:0]       numer;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff <= in_item;
         s2_pipe_ff <= s2_pipe_in;
         s2_div_ff  <= s2_div_in;
      end
   end

   always_comb begin
      lh_eff  = (s1_item_ff.wall_height == '0) ? LH_W'(1) : s1_item_ff.wall_height;
      row_off = $signed(N_W'(s1_item_ff.pixel_row)) - HALF_H
                + $signed(N_W'(lh_eff[LH_W-1:1]));
      row_mag = row_off[NMAG_W-1:0];
      // numerator row_off*TEX_SIZE; only meaningful when 0 <= row_off < lh
      numer   = NUMER_W'(row_mag) * NUMER_W'(TEX_SIZE);

      s2_pipe_in.cmd        = s1_item_ff.cmd;
      s2_pipe_in.tex_select = s1_item_ff.tex_select;
      s2_pipe_in.tex_col    = clamp_col(s1_item_ff.tex_col);
      s2_pipe_in.load_index = s1_item_ff.load_index;
      s2_pipe_in.load_color = s1_item_ff.load_color;
      s2_pipe_in.pixel_col  = s1_item_ff.pixel_col;
      s2_pipe_in.addr_prod  = ADDR_W'(s1_item_ff.pixel_row) * ADDR_W'(row_pitch);
      s2_pipe_in.row_zero   = row_off[N_W-1];
      s2_pipe_in.row_sat    = !row_off[N_W-1] && (row_mag >= NMAG_W'(lh_eff));

      // floor wins when the span is empty or inverted
      priority if (s1_item_ff.pixel_row > s1_item_ff.span_end) begin
         s2_pipe_in.region = REGION_FLOOR;
      end else if (s1_item_ff.pixel_row < s1_item_ff.span_start) begin
         s2_pipe_in.region = REGION_CEILING;
      end else begin
         s2_pipe_in.region = REGION_WALL;
      end

      s2_div_in.rem  = LH_W'(numer[NUMER_W-1:TEX_RW]);
      s2_div_in.low  = numer[TEX_RW-1:0];
      s2_div_in.quot = '0;
      s2_div_in.lh   = lh_eff;
   end

   assign out_valid = s2_valid_ff;
   assign out_pipe  = s2_pipe_ff;
   assign out_div   = s2_div_ff;

   `RCCPS_ASSERT_NEVER(a_row_clamp_excl, s2_valid_ff && s2_pipe_ff.row_zero && s2_pipe_ff.row_sat, "texel row clamped both low and high")

endmodule

/* sv/rccps_divider.sv */
`timescale 1ns / 1ps
`include "raycast_column_pixel_shader_assert.svh"

module rccps_divider import rccps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  pipe_type in_pipe,
   input  div_type  in_div,
   output logic     out_valid,
   output pipe_type out_pipe,
   output div_type  out_div
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_in;
   pipe_type              pipe_ff [DIV_STAGES];
   pipe_type              pipe_in [DIV_STAGES];
   div_type               div_ff  [DIV_STAGES];
   div_type               src_div [DIV_STAGES];
   div_type               div_in  [DIV_STAGES];

   assign valid_in[0] = in_valid;
   assign pipe_in[0]  = in_pipe;
   assign src_div[0]  = in_div;

   for (genvar s = 1; s < DIV_STAGES; s++) begin : g_link
      assign valid_in[s] = valid_ff[s-1];
      assign pipe_in[s]  = pipe_ff[s-1];
      assign src_div[s]  = div_ff[s-1];
   end

   // restoring division, DIV_BPS quotient bits per stage
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      always_comb begin
         div_type           d;
         logic [NMAG_W-1:0] trial;
         logic              fit;
         d     = src_div[s];
         trial = '0;
         fit   = 1'b0;
         for (int k = 0; k < DIV_BPS; k++) begin
            if (s * DIV_BPS + k < TEX_RW) begin
               trial  = {d.rem, d.low[TEX_RW-1]};
               fit    = trial >= NMAG_W'(d.lh);
               d.rem  = fit ? LH_W'(trial - NMAG_W'(d.lh)) : LH_W'(trial);
               d.quot = {d.quot[TEX_RW-2:0], fit};
               d.low  = d.low << 1;
            end
         end
         div_in[s] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            pipe_ff[s] <= pipe_in[s];
            div_ff[s]  <= div_in[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_pipe  = pipe_ff[DIV_STAGES-1];
   assign out_div   = div_ff[DIV_STAGES-1];

   `RCCPS_ASSERT_IMPLY(a_rem_bound, out_valid && !out_pipe.row_zero && !out_pipe.row_sat, out_div.rem < out_div.lh, "divider remainder not below wall height")

endmodule

/* sv/raycast_column_pixel_shader.sv */
`timescale 1ns / 1ps
`include "raycast_column_pixel_shader_assert.svh"

// Raycaster column pixel shader.
// req_ch carries one transaction per item: cmd selects a texel load (writes
// load_color into texture tex_select at load_index, no response) or a pixel
// shade (exactly one transaction on rsp_ch with frame address, color and
// region). csr_* writes ceiling color, floor color and row pitch; write them
// only while no transaction is in flight.
// Seven register stages: input, decode with the row*pitch multiply, three
// divider stages for the texel row (DIV_BPS quotient bits each), texture
// read issue, and the output register. One transaction per cycle is
// accepted and delivered as long as rsp_ch is not stalled.
// When rsp_ch holds ready low with a response pending, the whole pipeline
// freezes and req_ch.ready drops in the same cycle; nothing is dropped.
// Reset empties the pipeline and loads the register defaults (colors 0,
// pitch 1024). The texture store is not cleared; load a texel before any
// shade reads it.

module raycast_column_pixel_shader import rccps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rccps_req_if.sink            req_ch,
   rccps_rsp_if.source          rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_data
);

   logic [COLOR_W-1:0]  ceiling_ff;
   logic [COLOR_W-1:0]  floor_ff;
   logic [PITCH_W-1:0]  pitch_ff;

   logic                advance;
   item_type            req_item;

   logic                front_valid;
   pipe_type            front_pipe;
   div_type             front_div;
   logic                div_valid;
   pipe_type            div_pipe;
   div_type             div_res;

   logic [TEX_RW-1:0]   tex_row;
   logic                sel_ok;
   logic                ram_re;
   logic                ram_we;
   logic [STORE_AW-1:0] ram_raddr;
   logic [STORE_AW-1:0] ram_waddr;
   logic [COLOR_W-1:0]  ram_q;

   logic                s6_valid_ff;
   logic                s6_valid_in;
   logic [ADDR_W-1:0]   s6_addr_ff;
   logic [ADDR_W-1:0]   s6_addr_in;
   region_type          s6_region_ff;
   logic                s6_use_tex_ff;
   logic                s6_use_tex_in;
   logic [COLOR_W-1:0]  s6_color_ff;
   logic [COLOR_W-1:0]  s6_color_in;

   logic                out_valid_ff;
   logic [ADDR_W-1:0]   out_addr_ff;
   logic [COLOR_W-1:0]  out_color_ff;
   logic [COLOR_W-1:0]  out_color_in;
   region_type          out_region_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= '0;
         floor_ff   <= '0;
         pitch_ff   <= PITCH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CEILING_COLOR: ceiling_ff <= csr_data;
            CSR_FLOOR_COLOR:   floor_ff   <= csr_data;
            CSR_ROW_PITCH:     pitch_ff   <= csr_data[PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign req_item = '{
      cmd:         cmd_type'(req_ch.cmd),
      pixel_col:   req_ch.pixel_col,
      pixel_row:   req_ch.pixel_row,
      span_start:  req_ch.span_start,
      span_end:    req_ch.span_end,
      wall_height: req_ch.wall_height,
      tex_col:     req_ch.tex_col,
      tex_select:  req_ch.tex_select,
      load_index:  req_ch.load_index,
      load_color:  req_ch.load_color
   };

   rccps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_ch.valid),
      .in_item   (req_item),
      .row_pitch (pitch_ff),
      .out_valid (front_valid),
      .out_pipe  (front_pipe),
      .out_div   (front_div)
   );

   rccps_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_pipe   (front_pipe),
      .in_div    (front_div),
      .out_valid (div_valid),
      .out_pipe  (div_pipe),
      .out_div   (div_res)
   );

   // loads write at the same point where shades read, so store order follows
   // transaction order
   always_comb begin
      if (div_pipe.row_zero) begin
         tex_row = '0;
      end else if (div_pipe.row_sat) begin
         tex_row = TEX_RW'(TEX_SIZE - 1);
      end else begin
         tex_row = div_res.quot;
      end

      sel_ok    = tex_in_range(div_pipe.tex_select);
      ram_raddr = texel_addr(div_pipe.tex_select, tex_row, div_pipe.tex_col);
      ram_waddr = load_addr(div_pipe.tex_select, div_pipe.load_index);
      ram_re    = advance && div_valid && (div_pipe.cmd == CMD_SHADE)
                  && (div_pipe.region == REGION_WALL) && sel_ok;
      ram_we    = advance && div_valid && (div_pipe.cmd == CMD_LOAD)
                  && load_in_range(div_pipe.tex_select, div_pipe.load_index);

      s6_valid_in   = div_valid && (div_pipe.cmd == CMD_SHADE);
      s6_addr_in    = div_pipe.addr_prod + ADDR_W'(div_pipe.pixel_col);
      s6_use_tex_in = (div_pipe.region == REGION_WALL) && sel_ok;
      unique case (div_pipe.region)
         REGION_CEILING: s6_color_in = ceiling_ff;
         REGION_FLOOR:   s6_color_in = floor_ff;
         default:        s6_color_in = '0;
      endcase
   end

   rccps_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (STORE_DEPTH)
   ) u_tex_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (div_pipe.load_color),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign out_color_in = s6_use_tex_ff ? ram_q : s6_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff  <= s6_valid_in;
         out_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_addr_ff    <= s6_addr_in;
         s6_region_ff  <= div_pipe.region;
         s6_use_tex_ff <= s6_use_tex_in;
         s6_color_ff   <= s6_color_in;
         out_addr_ff   <= s6_addr_ff;
         out_color_ff  <= out_color_in;
         out_region_ff <= s6_region_ff;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.frame_address = out_addr_ff;
   assign rsp_ch.pixel_color   = out_color_ff;
   assign rsp_ch.region        = out_region_ff;

   `RCCPS_ASSERT_NEVER(a_ram_rw_clash, ram_re && ram_we, "texture read and write in one cycle")
   `RCCPS_ASSERT_NEXT(a_load_no_rsp, advance && div_valid && div_pipe.cmd == CMD_LOAD, !s6_valid_ff, "texel load produced a response")
   `RCCPS_ASSERT_NEXT(a_stall_hold, !advance, $stable(s6_valid_ff) && $stable(s6_addr_ff) && $stable(ram_q), "read stage moved during stall")

endmodule
